// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define CPD_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// Checked on every clock edge, reset included.
`define CPD_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("assertion failed");

`endif

// ----- rtl/cpd_pkg.sv -----
`default_nettype none
package cpd_pkg;

   localparam int ERROR_LIMIT = 20;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0]  END_MARKER = 8'hFF;
   localparam logic [10:0] POS_MAX    = 11'h7FF;
   localparam logic [4:0]  ERR_MAX    = 5'h1F;

   typedef enum logic [1:0] {
      KIND_PIXEL      = 2'd0,
      KIND_COLUMN_END = 2'd1,
      KIND_TOO_LONG   = 2'd2,
      KIND_ABORT      = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      REG_CLIP_LEFT         = 3'd0,
      REG_CLIP_RIGHT        = 3'd1,
      REG_CLIP_TOP          = 3'd2,
      REG_CLIP_BOTTOM       = 3'd3,
      REG_PADDED_POSTS      = 3'd4,
      REG_TRANSPARENT_INDEX = 3'd5,
      REG_SUBSTITUTE_COLOUR = 3'd6,
      REG_COLUMN_BYTE_LIMIT = 3'd7
   } csr_index_type;

   typedef enum logic [5:0] {
      PH_TOP      = 6'b000001,
      PH_LEN      = 6'b000010,
      PH_PAD_PRE  = 6'b000100,
      PH_PIX      = 6'b001000,
      PH_PAD_POST = 6'b010000,
      PH_DONE     = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        column_start;
      logic [11:0] column;
      logic        picture_start;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [8:0]  row;
      logic [11:0] pixel_column;
      logic [7:0]  colour;
   } rsp_type;

   typedef struct packed {
      kind_type    kind;
      logic [8:0]  row;
      logic [11:0] column;
      logic [7:0]  data;
   } cmd_type;

   typedef struct packed {
      logic [11:0] clip_left;
      logic [11:0] clip_right;
      logic [11:0] clip_top;
      logic [11:0] clip_bottom;
      logic        padded_posts;
      logic [7:0]  transparent_index;
      logic [7:0]  substitute_colour;
      logic [10:0] column_byte_limit;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

// ----- rtl/cpd_front.sv -----
`default_nettype none
module cpd_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire cpd_pkg::req_type  req_data,
   input  wire logic              full,
   input  wire cpd_pkg::cfg_type  cfg,
   output logic                   cmd_valid,
   output cpd_pkg::cmd_type       cmd
);

   cpd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  top_row_ff, top_row_in;
   logic [7:0]  remaining_ff, remaining_in;
   logic [8:0]  current_row_ff, current_row_in;
   logic [10:0] byte_position_ff, byte_position_in;
   logic [11:0] current_column_ff, current_column_in;
   logic [4:0]  error_count_ff, error_count_in;
   logic        aborted_ff, aborted_in;

   always_comb begin
      logic [10:0] pos;
      logic [7:0]  rem_next;
      logic [4:0]  err_next;
      phase_in          = phase_ff;
      top_row_in        = top_row_ff;
      remaining_in      = remaining_ff;
      current_row_in    = current_row_ff;
      byte_position_in  = byte_position_ff;
      current_column_in = current_column_ff;
      error_count_in    = error_count_ff;
      aborted_in        = aborted_ff;
      cmd_valid         = 1'b0;
      cmd               = '0;
      pos               = '0;
      rem_next          = '0;
      err_next          = '0;
      if (push && !full) begin
         if (req_data.picture_start) begin
            error_count_in = '0;
            aborted_in     = 1'b0;
         end
         if (req_data.picture_start || req_data.column_start) begin
            current_column_in = req_data.column;
            byte_position_in  = '0;
            phase_in          = cpd_pkg::PH_TOP;
         end
         cmd.column = current_column_in;
         if (!aborted_in && current_column_in >= cfg.clip_left
             && current_column_in <= cfg.clip_right) begin
            pos = byte_position_in;
            if (pos != cpd_pkg::POS_MAX) begin
               byte_position_in = pos + 11'd1;
            end
            unique case (phase_in)
               cpd_pkg::PH_TOP: begin
                  if (req_data.data_byte == cpd_pkg::END_MARKER) begin
                     cmd_valid = 1'b1;
                     cmd.kind  = cpd_pkg::KIND_COLUMN_END;
                     phase_in  = cpd_pkg::PH_DONE;
                  end else if (pos > cfg.column_byte_limit) begin
                     err_next = (error_count_in != cpd_pkg::ERR_MAX) ?
                                error_count_in + 5'd1 : error_count_in;
                     error_count_in = err_next;
                     cmd_valid = 1'b1;
                     if (err_next > 5'(cpd_pkg::ERROR_LIMIT)) begin
                        aborted_in = 1'b1;
                        cmd.kind   = cpd_pkg::KIND_ABORT;
                     end else begin
                        cmd.kind = cpd_pkg::KIND_TOO_LONG;
                     end
                     phase_in = cpd_pkg::PH_DONE;
                  end else begin
                     top_row_in = req_data.data_byte;
                     phase_in   = cpd_pkg::PH_LEN;
                  end
               end
               cpd_pkg::PH_LEN: begin
                  remaining_in   = req_data.data_byte;
                  current_row_in = {1'b0, top_row_ff};
                  if (cfg.padded_posts) begin
                     phase_in = cpd_pkg::PH_PAD_PRE;
                  end else if (req_data.data_byte != 8'd0) begin
                     phase_in = cpd_pkg::PH_PIX;
                  end else begin
                     phase_in = cpd_pkg::PH_TOP;
                  end
               end
               cpd_pkg::PH_PAD_PRE: begin
                  phase_in = (remaining_ff != 8'd0) ? cpd_pkg::PH_PIX
                                                    : cpd_pkg::PH_PAD_POST;
               end
               cpd_pkg::PH_PIX: begin
                  cmd_valid      = 1'b1;
                  cmd.kind       = cpd_pkg::KIND_PIXEL;
                  cmd.row        = current_row_ff;
                  cmd.data       = req_data.data_byte;
                  current_row_in = current_row_ff + 9'd1;
                  rem_next       = remaining_ff - 8'd1;
                  remaining_in   = rem_next;
                  if (rem_next == 8'd0) begin
                     phase_in = cfg.padded_posts ? cpd_pkg::PH_PAD_POST
                                                 : cpd_pkg::PH_TOP;
                  end
               end
               cpd_pkg::PH_PAD_POST: begin
                  phase_in = cpd_pkg::PH_TOP;
               end
               cpd_pkg::PH_DONE: begin
                  phase_in = cpd_pkg::PH_DONE;
               end
               default: begin
                  phase_in = cpd_pkg::PH_TOP;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= cpd_pkg::PH_TOP;
         top_row_ff        <= '0;
         remaining_ff      <= '0;
         current_row_ff    <= '0;
         byte_position_ff  <= '0;
         current_column_ff <= '0;
         error_count_ff    <= '0;
         aborted_ff        <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         top_row_ff        <= top_row_in;
         remaining_ff      <= remaining_in;
         current_row_ff    <= current_row_in;
         byte_position_ff  <= byte_position_in;
         current_column_ff <= current_column_in;
         error_count_ff    <= error_count_in;
         aborted_ff        <= aborted_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/cpd_queue.sv -----
`default_nettype none
module cpd_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       wr_valid,
   input  wire cpd_pkg::cmd_type           wr_data,
   input  wire logic                       rd_take,
   output cpd_pkg::cmd_type                rd_data,
   output cpd_pkg::queue_status_type       status
);

   cpd_pkg::cmd_type slot_ff [cpd_pkg::QUEUE_DEPTH];
   logic [cpd_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cpd_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cpd_pkg::QCNT_W-1:0] count_ff, count_in;
   logic do_write;
   logic do_read;

   assign status.full  = (count_ff == cpd_pkg::QCNT_W'(cpd_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_write     = wr_valid && !status.full;
   assign do_read      = rd_take && !status.empty;
   assign rd_data      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_write ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_read ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_write && !do_read) begin
         count_in = count_ff + 1'b1;
      end else if (do_read && !do_write) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/cpd_back.sv -----
`default_nettype none
module cpd_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cpd_pkg::queue_status_type  q_status,
   input  wire cpd_pkg::cmd_type           q_data,
   output logic                            q_take,
   input  wire cpd_pkg::cfg_type           cfg,
   input  wire logic                       pop,
   output logic                            empty,
   output cpd_pkg::rsp_type                rsp_data
);

   logic             out_valid_ff, out_valid_in;
   cpd_pkg::rsp_type out_ff, out_in;
   logic             keep;

   assign q_take   = !q_status.empty && (!out_valid_ff || pop);
   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

   always_comb begin
      out_in              = out_ff;
      out_valid_in        = out_valid_ff && !pop;
      keep                = 1'b1;
      if (q_data.kind == cpd_pkg::KIND_PIXEL) begin
         keep = ({3'b000, q_data.row} >= cfg.clip_top)
             && ({3'b000, q_data.row} <= cfg.clip_bottom);
      end
      if (q_take) begin
         out_valid_in        = keep;
         out_in.kind         = q_data.kind;
         out_in.pixel_column = q_data.column;
         out_in.row          = '0;
         out_in.colour       = '0;
         if (q_data.kind == cpd_pkg::KIND_PIXEL) begin
            out_in.row    = q_data.row;
            out_in.colour = (q_data.data == cfg.transparent_index) ?
                            cfg.substitute_colour : q_data.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/column_post_decoder_core.sv -----
`default_nettype none
// Decodes the post stream of picture columns, one byte per clock cycle, and
// produces pixel writes clipped to the configured window together with
// column end, post too long and abort items. The parser takes a byte in
// every cycle in which the four-entry command queue behind it has room; the
// output stage drops pixels outside the row window and substitutes the
// transparent index; a result passes the queue slot and the output register,
// and the block sustains one byte per cycle while results are taken.
`include "assert_macros.svh"
module column_post_decoder_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire cpd_pkg::req_type  req_data,
   output logic                   empty,
   input  wire logic              pop,
   output cpd_pkg::rsp_type       rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [4:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   cpd_pkg::cfg_type          cfg_ff, cfg_in;
   cpd_pkg::csr_index_type    csr_index;
   cpd_pkg::queue_status_type q_status;
   cpd_pkg::cmd_type          cmd;
   cpd_pkg::cmd_type          q_data;
   logic                      cmd_valid;
   logic                      q_take;
   logic                      rsp_pixel;
   logic                      rsp_fields_zero;
   logic                      rsp_row_ok;
   logic                      rsp_col_ok;

   assign pready    = 1'b1;
   assign csr_index = cpd_pkg::csr_index_type'(paddr[4:2]);
   assign full      = q_status.full;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite && pready) begin
         unique case (csr_index)
            cpd_pkg::REG_CLIP_LEFT:         cfg_in.clip_left = pwdata[11:0];
            cpd_pkg::REG_CLIP_RIGHT:        cfg_in.clip_right = pwdata[11:0];
            cpd_pkg::REG_CLIP_TOP:          cfg_in.clip_top = pwdata[11:0];
            cpd_pkg::REG_CLIP_BOTTOM:       cfg_in.clip_bottom = pwdata[11:0];
            cpd_pkg::REG_PADDED_POSTS:      cfg_in.padded_posts = pwdata[0];
            cpd_pkg::REG_TRANSPARENT_INDEX: cfg_in.transparent_index = pwdata[7:0];
            cpd_pkg::REG_SUBSTITUTE_COLOUR: cfg_in.substitute_colour = pwdata[7:0];
            cpd_pkg::REG_COLUMN_BYTE_LIMIT: cfg_in.column_byte_limit = pwdata[10:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (csr_index)
         cpd_pkg::REG_CLIP_LEFT:         prdata = {20'd0, cfg_ff.clip_left};
         cpd_pkg::REG_CLIP_RIGHT:        prdata = {20'd0, cfg_ff.clip_right};
         cpd_pkg::REG_CLIP_TOP:          prdata = {20'd0, cfg_ff.clip_top};
         cpd_pkg::REG_CLIP_BOTTOM:       prdata = {20'd0, cfg_ff.clip_bottom};
         cpd_pkg::REG_PADDED_POSTS:      prdata = {31'd0, cfg_ff.padded_posts};
         cpd_pkg::REG_TRANSPARENT_INDEX: prdata = {24'd0, cfg_ff.transparent_index};
         cpd_pkg::REG_SUBSTITUTE_COLOUR: prdata = {24'd0, cfg_ff.substitute_colour};
         cpd_pkg::REG_COLUMN_BYTE_LIMIT: prdata = {21'd0, cfg_ff.column_byte_limit};
         default:                        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clip_left         <= 12'd0;
         cfg_ff.clip_right        <= 12'd4095;
         cfg_ff.clip_top          <= 12'd0;
         cfg_ff.clip_bottom       <= 12'd4095;
         cfg_ff.padded_posts      <= 1'b1;
         cfg_ff.transparent_index <= 8'd247;
         cfg_ff.substitute_colour <= 8'd0;
         cfg_ff.column_byte_limit <= 11'd1300;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cpd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (q_status.full),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   cpd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (cmd_valid),
      .wr_data  (cmd),
      .rd_take  (q_take),
      .rd_data  (q_data),
      .status   (q_status)
   );

   cpd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .q_data   (q_data),
      .q_take   (q_take),
      .cfg      (cfg_ff),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data)
   );

   assign rsp_pixel       = !empty && (rsp_data.kind == cpd_pkg::KIND_PIXEL);
   assign rsp_fields_zero = (rsp_data.row == 9'd0) && (rsp_data.colour == 8'd0);
   assign rsp_row_ok      = ({3'b000, rsp_data.row} >= cfg_ff.clip_top)
                            && ({3'b000, rsp_data.row} <= cfg_ff.clip_bottom);
   assign rsp_col_ok      = (rsp_data.pixel_column >= cfg_ff.clip_left)
                            && (rsp_data.pixel_column <= cfg_ff.clip_right);

   `CPD_ASSERT_ALWAYS(a_reset_drains, reset |=> (empty && !full))
   `CPD_ASSERT(a_non_pixel_zero, (!empty && !rsp_pixel) |-> rsp_fields_zero)
   `CPD_ASSERT(a_pixel_in_rows, rsp_pixel |-> rsp_row_ok)
   `CPD_ASSERT(a_pixel_in_cols, rsp_pixel |-> rsp_col_ok)

endmodule
`default_nettype wire
